[src/ncp_pkg.sv]
package ncp_pkg;

    localparam int IN_WIDTH_DEF  = 24;
    localparam int OUT_FRAC_DEF  = 30;
    localparam int DIR_W         = 32;

    typedef enum logic {
        t_FUNC_NORM  = 1'b0,
        t_FUNC_CROSS = 1'b1
    } t_func;

endpackage

[src/ncp_square.sv]
module ncp_square
    import ncp_pkg::*;
#(
    parameter int IN_WIDTH = IN_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [2*IN_WIDTH-1:0]   i_mag,
    input  logic                    i_neg,
    output logic [4*IN_WIDTH-1:0]   o_sq,
    output logic                    o_neg
);

    localparam int W  = IN_WIDTH;
    localparam int QW = 4 * IN_WIDTH;

    logic [2*W-1:0] r_hh;
    logic [2*W-1:0] r_hl;
    logic [2*W-1:0] r_ll;
    logic           r_neg1;
    logic [QW-1:0]  r_sq;
    logic           r_neg2;
    logic [QW-1:0]  n_sq;

    // split square into three narrow partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh   <= i_mag[2*W-1:W] * i_mag[2*W-1:W];
            r_hl   <= i_mag[2*W-1:W] * i_mag[W-1:0];
            r_ll   <= i_mag[W-1:0] * i_mag[W-1:0];
            r_neg1 <= i_neg;
        end
    end

    always_comb begin
        n_sq = (QW'(r_hh) << (2*W)) + (QW'(r_hl) << (W+1)) + QW'(r_ll);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq   <= n_sq;
            r_neg2 <= r_neg1;
        end
    end

    assign o_sq  = r_sq;
    assign o_neg = r_neg2;

endmodule

[src/ncp_norm.sv]
module ncp_norm
    import ncp_pkg::*;
#(
    parameter int IN_WIDTH      = IN_WIDTH_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [4*IN_WIDTH+1:0]   i_sq,
    input  logic [4*IN_WIDTH+1:0]   i_den,
    input  logic                    i_neg,
    output logic [DIR_W-1:0]        o_dir
);

    localparam int F   = OUT_FRAC_BITS;
    localparam int SW  = 4 * IN_WIDTH + 2;
    localparam int QW  = 2 * F + 1;
    localparam int D   = 2 * F + 1;
    localparam int R   = F + 1;
    localparam int RTW = F + 1;
    localparam int TW  = QW + 1;
    localparam int EW  = (F + 2 > DIR_W) ? F + 2 : DIR_W;

    logic [SW-1:0]  r_rem  [D];
    logic [SW-1:0]  r_den  [D];
    logic [QW-1:0]  r_q    [D];
    logic           r_dneg [D];
    logic [QW-1:0]  r_srem [R];
    logic [RTW-1:0] r_root [R];
    logic           r_sneg [R];
    logic [EW-1:0]  ext;
    logic [EW-1:0]  sdir;

    // restoring division, one quotient bit a stage
    for (genvar k = 0; k < D; k++) begin : g_div
        logic [SW:0]   t;
        logic [SW-1:0] den_in;
        logic [QW-1:0] q_in;
        logic          neg_in;
        logic          ge;
        logic [SW:0]   diff;
        if (k == 0) begin : g_first
            assign t      = {1'b0, i_sq};
            assign den_in = i_den;
            assign q_in   = '0;
            assign neg_in = i_neg;
        end else begin : g_next
            assign t      = {r_rem[k-1], 1'b0};
            assign den_in = r_den[k-1];
            assign q_in   = r_q[k-1];
            assign neg_in = r_dneg[k-1];
        end
        assign ge   = t >= {1'b0, den_in};
        assign diff = t - {1'b0, den_in};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[SW-1:0] : t[SW-1:0];
                r_den[k]  <= den_in;
                r_q[k]    <= {q_in[QW-2:0], ge};
                r_dneg[k] <= neg_in;
            end
        end
    end

    // digit-by-digit square root, one root bit a stage
    for (genvar j = 0; j < R; j++) begin : g_sqrt
        localparam int B = F - j;
        logic [QW-1:0]  rem_in;
        logic [RTW-1:0] root_in;
        logic           neg_in;
        logic [TW-1:0]  trial;
        logic           ok;
        logic [TW-1:0]  diff;
        if (j == 0) begin : g_first
            assign rem_in  = r_q[D-1];
            assign root_in = '0;
            assign neg_in  = r_dneg[D-1];
        end else begin : g_next
            assign rem_in  = r_srem[j-1];
            assign root_in = r_root[j-1];
            assign neg_in  = r_sneg[j-1];
        end
        assign trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
        assign ok    = trial <= TW'(rem_in);
        assign diff  = TW'(rem_in) - trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_srem[j] <= ok ? diff[QW-1:0] : rem_in;
                r_root[j] <= root_in | (RTW'(ok) << B);
                r_sneg[j] <= neg_in;
            end
        end
    end

    always_comb begin
        ext  = EW'(r_root[R-1]);
        sdir = r_sneg[R-1] ? (EW'(0) - ext) : ext;
    end

    assign o_dir = sdir[DIR_W-1:0];

endmodule

[src/normalized_cross_product_3d_core.sv]
// Normalized 3D direction and normalized cross product. Each word carries an
// operation (normalize a, or normalize a x b) and two signed fixed-point
// vectors; the result is a unit direction in signed Q1.OUT_FRAC_BITS with a
// flag for a zero-length vector (outputs then zero). Fully pipelined: one
// word per cycle while o_stall is low; the pipeline's length is set mostly by
// the per-bit division and square-root stages of the three component lanes.
// A two-entry output buffer absorbs stall.
module normalized_cross_product_3d_core
    import ncp_pkg::*;
#(
    parameter int IN_WIDTH      = IN_WIDTH_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_func,
    input  logic signed [IN_WIDTH-1:0]  i_a_x,
    input  logic signed [IN_WIDTH-1:0]  i_a_y,
    input  logic signed [IN_WIDTH-1:0]  i_a_z,
    input  logic signed [IN_WIDTH-1:0]  i_b_x,
    input  logic signed [IN_WIDTH-1:0]  i_b_y,
    input  logic signed [IN_WIDTH-1:0]  i_b_z,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [DIR_W-1:0]     o_dir_x,
    output logic signed [DIR_W-1:0]     o_dir_y,
    output logic signed [DIR_W-1:0]     o_dir_z,
    output logic                        o_zero_length
);

    localparam int W  = IN_WIDTH;
    localparam int F  = OUT_FRAC_BITS;
    localparam int MW = 2 * W;
    localparam int VW = 2 * W + 1;
    localparam int SW = 4 * W + 2;
    localparam int D  = 2 * F + 1;
    localparam int R  = F + 1;
    localparam int L  = 5 + D + R;
    localparam int ZL = D + R + 1;

    logic signed [W-1:0]  a_in [3];
    logic signed [W-1:0]  b_in [3];
    logic signed [MW-1:0] r_pp [3];
    logic signed [MW-1:0] r_pm [3];
    logic signed [W-1:0]  r_a  [3];
    t_func                r_func;
    logic [MW-1:0]        r_mag [3];
    logic                 r_neg2 [3];
    logic [4*W-1:0]       sq   [3];
    logic                 sneg [3];
    logic [SW-1:0]        r_sq5 [3];
    logic                 r_neg5 [3];
    logic [SW-1:0]        r_sum;
    logic [SW-1:0]        n_sum;
    logic [DIR_W-1:0]     dir  [3];
    logic [L-1:0]         r_vld;
    logic [ZL-1:0]        r_zr;
    logic                 en;
    logic                 take;
    logic                 last;
    logic                 r_out_vld;
    logic                 r_skd_vld;
    logic [DIR_W-1:0]     r_out [3];
    logic [DIR_W-1:0]     r_skd [3];
    logic                 r_out_z;
    logic                 r_skd_z;
    logic [DIR_W-1:0]     new_dir [3];

    assign a_in[0] = i_a_x;
    assign a_in[1] = i_a_y;
    assign a_in[2] = i_a_z;
    assign b_in[0] = i_b_x;
    assign b_in[1] = i_b_y;
    assign b_in[2] = i_b_z;

    assign en   = !r_skd_vld;
    assign take = r_out_vld && !i_stall;
    assign last = en && r_vld[L-1];

    for (genvar i = 0; i < 3; i++) begin : g_lane
        localparam int I1 = (i + 1) % 3;
        localparam int I2 = (i + 2) % 3;
        logic signed [VW-1:0] v;
        logic signed [VW-1:0] mv;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_pp[i] <= a_in[I1] * b_in[I2];
                r_pm[i] <= a_in[I2] * b_in[I1];
                r_a[i]  <= a_in[i];
            end
        end

        always_comb begin
            v  = (r_func == t_FUNC_CROSS) ? (VW'(r_pp[i]) - VW'(r_pm[i])) : VW'(r_a[i]);
            mv = v[VW-1] ? (VW'(0) - v) : v;
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_mag[i]  <= mv[MW-1:0];
                r_neg2[i] <= v[VW-1];
            end
        end

        ncp_square #(
            .IN_WIDTH (IN_WIDTH)
        ) u_square (
            .i_clk (i_clk),
            .i_en  (en),
            .i_mag (r_mag[i]),
            .i_neg (r_neg2[i]),
            .o_sq  (sq[i]),
            .o_neg (sneg[i])
        );

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq5[i]  <= SW'(sq[i]);
                r_neg5[i] <= sneg[i];
            end
        end

        ncp_norm #(
            .IN_WIDTH      (IN_WIDTH),
            .OUT_FRAC_BITS (OUT_FRAC_BITS)
        ) u_norm (
            .i_clk (i_clk),
            .i_en  (en),
            .i_sq  (r_sq5[i]),
            .i_den (r_sum),
            .i_neg (r_neg5[i]),
            .o_dir (dir[i])
        );

        assign new_dir[i] = r_zr[ZL-1] ? '0 : dir[i];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_func <= t_func'(i_func);
        end
    end

    // merge: shared denominator for all lanes
    always_comb begin
        n_sum = SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum <= n_sum;
            r_zr  <= {r_zr[ZL-2:0], (n_sum == '0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[L-2:0], i_valid};
        end
    end

    // output register with one skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (r_skd_vld) begin
            if (take) begin
                r_skd_vld <= 1'b0;
            end
        end else if (last) begin
            if (!r_out_vld || take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skd_vld <= 1'b1;
            end
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_vld) begin
            if (take) begin
                r_out   <= r_skd;
                r_out_z <= r_skd_z;
            end
        end else if (last) begin
            if (!r_out_vld || take) begin
                r_out   <= new_dir;
                r_out_z <= r_zr[ZL-1];
            end else begin
                r_skd   <= new_dir;
                r_skd_z <= r_zr[ZL-1];
            end
        end
    end

    assign o_stall       = r_skd_vld;
    assign o_valid       = r_out_vld;
    assign o_dir_x       = r_out[0];
    assign o_dir_y       = r_out[1];
    assign o_dir_z       = r_out[2];
    assign o_zero_length = r_out_z;

endmodule
